// ----- src/planar_to_chunky_interleaver_defines.svh -----
// Assertion macros for the planar to chunky interleaver.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PLANAR_TO_CHUNKY_INTERLEAVER_DEFINES_SVH
`define PLANAR_TO_CHUNKY_INTERLEAVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define P2C_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("planar_to_chunky_interleaver: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("planar_to_chunky_interleaver: next-cycle check failed");

`else

`define P2C_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/p2c_pkg.sv -----
// Shared types, constants and packing functions for the planar to chunky interleaver.
// No dependencies.
`timescale 1ns / 1ps

package p2c_pkg;

   localparam int unsigned PlaneCount   = 4;
   localparam int unsigned ByteBits     = 8;
   localparam int unsigned MaxBytes     = 12;
   localparam int unsigned BufBits      = MaxBytes * ByteBits;
   localparam int unsigned CntBits      = 4;
   localparam int unsigned PlaneCntBits = 3;
   localparam int unsigned SampleBits   = 4;

   typedef logic [PlaneCount-1:0][ByteBits-1:0] column_type;
   typedef logic [BufBits-1:0]                  buf_type;
   typedef logic [CntBits-1:0]                  cnt_type;

   typedef enum logic {
      CSR_PLANE_COUNT = 1'b0,
      CSR_SAMPLE_BITS = 1'b1
   } csr_index_type;

   // Packs one column at 1, 2, 4 or 8 bits per sample. The result is left aligned:
   // the first output byte sits in bits [31:24].
   function automatic logic [31:0] narrow_pack(input column_type col, input logic four,
                                               input logic [SampleBits-1:0] k);
      logic [31:0] acc;
      int          np;
      int          klog;
      int          pos;
      acc  = '0;
      np   = four ? 4 : 3;
      unique case (k)
         4'd1:    klog = 0;
         4'd2:    klog = 1;
         4'd4:    klog = 2;
         default: klog = 3;
      endcase
      for (int p = 0; p < 4; p++) begin
         for (int b = 0; b < 8; b++) begin
            if (p < np) begin
               // Bit b (MSB first) of plane p belongs to sample b >> klog.
               pos = ((((b >> klog) * np) + p) << klog) + (b & ((1 << klog) - 1));
               acc[5'(31 - pos)] = col[2'(p)][3'(7 - b)];
            end
         end
      end
      return acc;
   endfunction

   // Packs a full 12-bit group of two pixels, left aligned in the result buffer.
   function automatic buf_type wide_pack(input column_type c0, input column_type c1,
                                         input column_type c2, input logic four);
      logic [PlaneCount-1:0][11:0] v0;
      logic [PlaneCount-1:0][11:0] v1;
      buf_type                     res;
      for (int p = 0; p < PlaneCount; p++) begin
         v0[p] = {c0[p], c1[p][7:4]};
         v1[p] = {c1[p][3:0], c2[p]};
      end
      if (four) begin
         res = {v0[0], v0[1], v0[2], v0[3], v1[0], v1[1], v1[2], v1[3]};
      end else begin
         res = {v0[0], v0[1], v0[2], v1[0], v1[1], v1[2], 24'd0};
      end
      return res;
   endfunction

endpackage

// ----- src/planar_to_chunky_interleaver.sv -----
// An accepted item is registered in A and moves on to B once B is free; B offers its result bytes.
// Output: one result byte per cycle while rsp_tready is high, set by the single output byte lane;
// a column gives 3 or 4 bytes at 1, 2, 4 or 8 bits per sample, a 12-bit group of three columns
// gives 9 or 12 bytes, and an unsupported setup gives 1 error byte per item.
// Reset is synchronous and active high; it clears control state and restores the
// registers to four planes and 8 bits per sample. Held 12-bit columns are not cleared.
`timescale 1ns / 1ps
`include "planar_to_chunky_interleaver_defines.svh"

module planar_to_chunky_interleaver
   import p2c_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [SampleBits-1:0]   csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
   input  logic                    req_tlast,   // row_end
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // out_byte
   output logic                    rsp_tlast,   // last
   output logic                    rsp_tuser    // error
);

   logic [PlaneCntBits-1:0] plane_count_ff;
   logic [SampleBits-1:0]   sample_bits_ff;
   logic [1:0]              phase_ff, phase_in;
   column_type              held_ff [2];

   buf_type  a_bytes_ff, a_bytes_in;
   cnt_type  a_cnt_ff, a_cnt_in;
   logic     a_err_ff, a_err_in;
   logic     a_valid_ff, a_valid_in;

   buf_type  b_bytes_ff, b_bytes_in;
   cnt_type  b_cnt_ff, b_cnt_in;
   logic     b_err_ff, b_err_in;
   logic     b_valid_ff, b_valid_in;

   column_type col;
   logic       accept, four, cfg_ok, b_done, b_free, move, held_we, held_sel;

   assign col    = column_type'(req_tdata);
   assign four   = (plane_count_ff == PlaneCntBits'(4));
   assign cfg_ok = (plane_count_ff == PlaneCntBits'(3) || four) &&
                   (sample_bits_ff == 4'd1 || sample_bits_ff == 4'd2 ||
                    sample_bits_ff == 4'd4 || sample_bits_ff == 4'd8 ||
                    sample_bits_ff == 4'd12);

   assign b_done     = rsp_tvalid && rsp_tready && (b_cnt_ff == cnt_type'(1));
   assign b_free     = !b_valid_ff || b_done;
   assign move       = a_valid_ff && b_free;
   assign req_tready = !a_valid_ff || move;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_bytes_ff[BufBits-1 -: ByteBits];
   assign rsp_tlast  = (b_cnt_ff == cnt_type'(1));
   assign rsp_tuser  = b_err_ff;

   // Work out every result byte of the arriving item in one pass.
   always_comb begin
      a_bytes_in = '0;
      a_cnt_in   = '0;
      a_err_in   = 1'b0;
      phase_in   = phase_ff;
      held_we    = 1'b0;
      held_sel   = 1'b0;
      if (!cfg_ok) begin
         a_cnt_in = cnt_type'(1);
         a_err_in = 1'b1;
         phase_in = 2'd0;
      end else if (sample_bits_ff != 4'd12) begin
         a_bytes_in = {narrow_pack(col, four, sample_bits_ff), {(BufBits-32){1'b0}}};
         a_cnt_in   = four ? cnt_type'(4) : cnt_type'(3);
         phase_in   = 2'd0;
      end else begin
         if (phase_ff == 2'd2) begin
            a_bytes_in = wide_pack(held_ff[0], held_ff[1], col, four);
            a_cnt_in   = four ? cnt_type'(12) : cnt_type'(9);
            phase_in   = 2'd0;
         end else begin
            // An unreached phase of three counts as the start of a group.
            held_we  = 1'b1;
            held_sel = (phase_ff == 2'd1);
            phase_in = held_sel ? 2'd2 : 2'd1;
         end
         if (req_tlast) begin
            phase_in = 2'd0;
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = (a_cnt_in != '0);
      end else if (move) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_bytes_in = b_bytes_ff;
      b_cnt_in   = b_cnt_ff;
      b_err_in   = b_err_ff;
      b_valid_in = b_valid_ff;
      if (move) begin
         b_bytes_in = a_bytes_ff;
         b_cnt_in   = a_cnt_ff;
         b_err_in   = a_err_ff;
         b_valid_in = 1'b1;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         b_bytes_in = {b_bytes_ff[BufBits-ByteBits-1:0], {ByteBits{1'b0}}};
         b_cnt_in   = b_cnt_ff - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= PlaneCntBits'(4);
         sample_bits_ff <= 4'd8;
         phase_ff       <= 2'd0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_PLANE_COUNT: plane_count_ff <= csr_wdata[PlaneCntBits-1:0];
               CSR_SAMPLE_BITS: sample_bits_ff <= csr_wdata;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in;
         end
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_bytes_ff <= a_bytes_in;
         a_cnt_ff   <= a_cnt_in;
         a_err_ff   <= a_err_in;
      end
      if (accept && held_we) begin
         held_ff[held_sel] <= col;
      end
      b_bytes_ff <= b_bytes_in;
      b_cnt_ff   <= b_cnt_in;
      b_err_ff   <= b_err_in;
   end

   `P2C_ASSERT_IMPLY(a_cnt_nonzero, clock, reset, a_valid_ff, a_cnt_ff != '0)
   `P2C_ASSERT_IMPLY(b_cnt_range, clock, reset, b_valid_ff,
      b_cnt_ff != '0 && b_cnt_ff <= cnt_type'(MaxBytes))
   `P2C_ASSERT_IMPLY(err_single_zero, clock, reset, b_valid_ff && b_err_ff,
      rsp_tlast && rsp_tdata == 8'd0)
   `P2C_ASSERT_IMPLY(phase_reached, clock, reset, 1'b1, phase_ff != 2'd3)
   `P2C_ASSERT_NEXT(move_loads_count, clock, reset, move,
      b_valid_ff && b_cnt_ff == $past(a_cnt_ff))

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for planar_to_chunky_interleaver: drives columns at random pace,
// predicts the chunky bytes in a scoreboard class and compares every output item.
// Depends on p2c_pkg and the planar_to_chunky_interleaver RTL.
`timescale 1ns / 1ps

module tb_top
   import p2c_pkg::*;
();

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } chunky_byte_type;

   // Tracks the interleaver state and holds the bytes it is expected to emit.
   class chunky_scoreboard_type;
      chunky_byte_type expected_bytes[$];
      int              mismatches;
      logic [2:0]      plane_cnt;
      logic [3:0]      sample_width;
      logic [1:0]      group_phase;
      logic [7:0]      held_bytes[8];

      function new();
         mismatches   = 0;
         plane_cnt    = 3'd4;
         sample_width = 4'd8;
         group_phase  = 2'd0;
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      endfunction

      function void write_reg(csr_index_type idx, logic [3:0] value);
         if (idx == CSR_PLANE_COUNT) begin
            plane_cnt = value[2:0];
         end else begin
            sample_width = value;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void push_byte(logic [7:0] b, logic last, logic err);
         chunky_byte_type item;
         item.out_byte = b;
         item.last     = last;
         item.error    = err;
         expected_bytes.push_back(item);
      endfunction

      // Works out the bytes caused by one accepted column.
      function void note_column(column_type col, logic row_end);
         logic [31:0] acc;
         logic [31:0] mask;
         logic [95:0] pixels;
         logic [11:0] sample;
         int          np;
         int          bps;
         int          shift;
         int          nbytes;
         bit          supported;
         np  = plane_cnt;
         bps = sample_width;
         case (sample_width)
            4'd1, 4'd2, 4'd4, 4'd8, 4'd12: supported = (np == 3 || np == 4);
            default:                       supported = 1'b0;
         endcase
         if (!supported) begin
            group_phase = 2'd0;
            push_byte(8'h00, 1'b1, 1'b1);
            return;
         end
         if (bps != 12) begin
            group_phase = 2'd0;
            acc  = '0;
            mask = (32'd1 << bps) - 32'd1;
            for (int s = 0; s < 8 / bps; s++) begin
               shift = 8 - bps * (s + 1);
               for (int p = 0; p < np; p++) begin
                  acc = (acc << bps) | ((32'(col[p]) >> shift) & mask);
               end
            end
            for (int i = 0; i < np; i++) begin
               push_byte(8'(acc >> (8 * (np - 1 - i))), i == np - 1, 1'b0);
            end
         end else if (group_phase == 2'd2) begin
            // Third column of a group: two whole pixels of 12-bit samples.
            pixels = '0;
            for (int px = 0; px < 2; px++) begin
               for (int p = 0; p < np; p++) begin
                  sample = (px == 0) ? {held_bytes[p], held_bytes[4 + p][7:4]}
                                     : {held_bytes[4 + p][3:0], col[p]};
                  pixels = {pixels[83:0], sample};
               end
            end
            nbytes = 3 * np;
            for (int i = 0; i < nbytes; i++) begin
               push_byte(8'(pixels >> (8 * (nbytes - 1 - i))), i == nbytes - 1, 1'b0);
            end
            group_phase = 2'd0;
         end else if (group_phase == 2'd3) begin
            for (int p = 0; p < np; p++) held_bytes[p] = col[p];
            group_phase = 2'd1;
         end else begin
            for (int p = 0; p < np; p++) held_bytes[group_phase * 4 + p] = col[p];
            group_phase = group_phase + 2'd1;
         end
         if (row_end) group_phase = 2'd0;
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [7:0] b, logic last, logic err);
         chunky_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h last %b error %b with none expected",
                                      b, last, err));
         end else begin
            want = expected_bytes.pop_front();
            if (b !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h", b, want.out_byte));
            if (last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", last, want.last));
            if (err !== want.error)
               report_mismatch($sformatf("error %b, expected %b", err, want.error));
         end
      endtask

      task check_drained();
         if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic            csr_addr;
   logic [3:0]      csr_wdata;
   logic            req_tvalid;
   logic            req_tready;
   logic [31:0]     req_tdata;   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
   logic            req_tlast;   // row_end
   logic            rsp_tvalid;
   logic            rsp_tready;
   logic [7:0]      rsp_tdata;   // out_byte
   logic            rsp_tlast;   // last
   logic            rsp_tuser;   // error

   chunky_scoreboard_type sb = new();
   bit                    quiet = 1'b0;
   bit                    hold_off_req = 1'b0;
   int                    items_sent = 0;

   planar_to_chunky_interleaver i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task send_column(column_type col, logic row_end);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tdata  = col;
      req_tlast  = row_end;
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_column(col, row_end);
      items_sent++;
      @(negedge clock);
   endtask

   // Waits until the block has drained, then writes both registers.
   task set_mode(logic [2:0] planes, logic [3:0] bits);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      // A 12-bit column that caused no bytes may still be in flight.
      repeat (8) @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = CSR_PLANE_COUNT;
      csr_wdata = {1'($urandom), planes};
      sb.write_reg(CSR_PLANE_COUNT, csr_wdata);
      @(negedge clock);
      csr_addr  = CSR_SAMPLE_BITS;
      csr_wdata = bits;
      sb.write_reg(CSR_SAMPLE_BITS, bits);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random columns cut into rows, mostly whole 12-bit groups; the last column ends a row
   // so that the next setting starts a fresh group.
   task run_rows(int count);
      int row_left;
      row_left = 0;
      for (int i = 0; i < count; i++) begin
         if (row_left == 0)
            row_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5)
                                                   : 3 * $urandom_range(1, 3);
         quiet = (items_sent >= 170);
         send_column($urandom, row_left == 1 || i == count - 1);
         row_left--;
      end
   endtask

   // Result side: random stalls and one long hold-off while the sender keeps offering.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_tready   = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   initial begin
      logic [2:0] planes;
      logic [3:0] bits;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = CSR_PLANE_COUNT;
      csr_wdata  = 4'd0;
      req_tvalid = 1'b0;
      req_tdata  = 32'd0;
      req_tlast  = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from the reset setting of four planes at 8 bits.
      send_column(32'h0000_0000, 1'b0);
      send_column(32'hFFFF_FFFF, 1'b0);
      send_column(32'h8001_7EC3, 1'b1);
      set_mode(3'd4, 4'd1);
      send_column(32'hA5C3_0FF0, 1'b1);
      // Plane three must be ignored with three planes.
      set_mode(3'd3, 4'd2);
      send_column(32'hFF1B_E427, 1'b1);
      set_mode(3'd4, 4'd4);
      send_column(32'h1234_5678, 1'b1);
      set_mode(3'd3, 4'd12);
      send_column(32'hFFAB_CDEF, 1'b0);
      send_column(32'h0012_3456, 1'b0);
      send_column(32'hFF78_9A0F, 1'b1);
      // Rows that end inside a group drop the partial group.
      send_column(32'h0011_2233, 1'b0);
      send_column(32'h0044_5566, 1'b1);
      send_column(32'h0077_8899, 1'b1);
      set_mode(3'd4, 4'd12);
      send_column(32'hFFFF_FFFF, 1'b0);
      send_column(32'h0F1E_2D3C, 1'b0);
      send_column(32'h0000_0000, 1'b0);
      send_column(32'hC001_D00F, 1'b1);
      // Unsupported settings, including the register extremes.
      set_mode(3'd7, 4'd8);
      send_column(32'hDEAD_BEEF, 1'b0);
      set_mode(3'd2, 4'd12);
      send_column(32'h1357_9BDF, 1'b1);
      set_mode(3'd3, 4'd0);
      send_column(32'h2468_ACE0, 1'b0);
      set_mode(3'd4, 4'd15);
      send_column(32'hFFFF_FFFF, 1'b1);
      set_mode(3'd3, 4'd8);
      send_column(32'hFFFF_FFFF, 1'b1);

      // Random part: the first setting runs against the long receiver hold-off.
      set_mode(3'd4, 4'd8);
      hold_off_req = 1'b1;
      run_rows(20);
      while (items_sent < 200) begin
         if ($urandom_range(0, 9) == 0) begin
            planes = 3'($urandom_range(0, 7));
            bits   = 4'($urandom_range(0, 15));
         end else begin
            planes = $urandom_range(0, 1) ? 3'd4 : 3'd3;
            case ($urandom_range(0, 5))
               0:       bits = 4'd1;
               1:       bits = 4'd2;
               2:       bits = 4'd4;
               3:       bits = 4'd8;
               default: bits = 4'd12;
            endcase
         end
         set_mode(planes, bits);
         run_rows($urandom_range(8, 24));
      end

      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      sb.check_drained();
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/p2c_pkg.sv
src/planar_to_chunky_interleaver.sv
test/tb_top.sv
